>>> hdl/logb_pkg.sv
// Shared types, constants and tables of the lidar occupancy grid builder.
package logb_pkg;

  localparam int GRID_W = 128;
  localparam int GRID_H = 128;
  localparam int COL_W = 7;
  localparam int ROW_W = 7;
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int DEPTH = GRID_W * GRID_H;
  localparam int INNER_R = 2;
  localparam int OUTER_R = 2;
  localparam int GOAL_MARGIN = 5 + INNER_R + OUTER_R;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_SAMPLE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_FINISH = 2'd3;

  localparam logic [3:0] CELL_FREE = 4'd0;
  localparam logic [3:0] CELL_BUF  = 4'd5;
  localparam logic [3:0] CELL_OBS  = 4'd9;

  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [16:0] PI_Q13 = 17'sd25736;
  localparam logic [15:0] GAIN_Q16 = 16'd39797;
  localparam int CORDIC_N = 16;
  localparam int CW = 36;

  // Paint list: centre, then per direction the 5 ring and the 9 ring.
  localparam int PAINT_N = 1 + 4 * ((OUTER_R + 1) + INNER_R);
  localparam int PIDX_W = $clog2(PAINT_N + 1);

  typedef struct packed {
    logic start_cordic;
    logic start_div;
    logic wr_en;
    logic wr_from_clear;
    logic rd_en;
    logic load_result;
    logic [1:0] req;
    logic [PIDX_W-1:0] paint_idx;
  } logb_cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic div_done;
    logic in_grid;
    logic paint_valid;
  } logb_sts_t;

  function automatic logic signed [CW-1:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0: atan_q16 = 36'sd51472;
      4'd1: atan_q16 = 36'sd30385;
      4'd2: atan_q16 = 36'sd16055;
      4'd3: atan_q16 = 36'sd8150;
      4'd4: atan_q16 = 36'sd4091;
      4'd5: atan_q16 = 36'sd2047;
      4'd6: atan_q16 = 36'sd1024;
      4'd7: atan_q16 = 36'sd512;
      4'd8: atan_q16 = 36'sd256;
      4'd9: atan_q16 = 36'sd128;
      4'd10: atan_q16 = 36'sd64;
      4'd11: atan_q16 = 36'sd32;
      4'd12: atan_q16 = 36'sd16;
      4'd13: atan_q16 = 36'sd8;
      4'd14: atan_q16 = 36'sd4;
      default: atan_q16 = 36'sd2;
    endcase
  endfunction

endpackage

>>> hdl/lidar_occupancy_grid_builder.sv
// Top level of the lidar occupancy grid builder.
//
//  channel | direction | tdata fields (low bit up)                         | tuser
//  in_     | slave     | distance[15:0] angle[31:16] col[38:32] row[45:39] | req_type[1:0]
//  out_    | master    | cell_value[3:0] sample_in_range[4] goal_row[11:5] | none
//
// One transaction is processed at a time. A sample that lands in the grid passes through
// the CORDIC iteration unit and the reciprocal divider, then its 21 paint-list cells that
// fall inside the grid are written on the single grid RAM port and the result is loaded;
// the next transaction can be taken in the cycle after the load. A sample outside the
// grid skips the writes. A clear sweeps the grid RAM one cell per cycle before its result
// loads. After reset that same clearing pass runs, and in_tready rises once it is done.
// The output register holds a result while out_tready is low; the next transaction may
// be accepted and worked on meanwhile, but it then waits with its result, and in_tready
// stays low until the output register drains.
module lidar_occupancy_grid_builder import logb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // sample_distance, sample_angle, cell_column, cell_row
  input  logic [1:0]  in_tuser,  // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata  // cell_value, sample_in_range, goal_row
);
  logb_cmd_t cmd;
  logb_sts_t sts;
  logic busy, clr_last, in_fire, ov_r;
  logic [3:0] cv;
  logic hv;
  logic [ROW_W-1:0] gv;

  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;

  logb_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_req(in_tuser),
    .out_free(!ov_r || out_tready), .clr_last(clr_last), .sts(sts), .cmd(cmd),
    .busy(busy));

  logb_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_dist(in_tdata[15:0]),
    .in_ang(in_tdata[31:16]), .in_col(in_tdata[38:32]), .in_row(in_tdata[45:39]),
    .cmd(cmd), .sts(sts), .clr_last(clr_last), .res_cell(cv), .res_hit(hv),
    .res_goal(gv));

  // The reset pass is a clear; its completion must not emit a result.
  logic boot_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; boot_r <= 1'b1;
    end else begin
      if (cmd.load_result) boot_r <= 1'b0;
      if (cmd.load_result && !boot_r) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {4'b0, gv, hv, cv};
endmodule

>>> hdl/logb_ram.sv
// Generic single-port RAM with a registered read.
module logb_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> hdl/logb_ctrl.sv
// Sequencer for clear sweeps, CORDIC, division, painting and reads.
module logb_ctrl import logb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [1:0]  in_req,
  input  logic        out_free,
  input  logic        clr_last,
  input  logb_sts_t   sts,
  output logb_cmd_t   cmd,
  output logic        busy
);
  localparam logic [2:0] S_IDLE = 3'd0, S_CLEAR = 3'd1, S_CORD = 3'd2, S_DIV = 3'd3,
                         S_PAINT = 3'd4, S_READ = 3'd5, S_DONE = 3'd6;
  logic [2:0] st_r, st_nxt;
  logic [1:0] req_r, req_nxt;
  logic [PIDX_W-1:0] pi_r, pi_nxt;

  always_comb begin
    st_nxt = st_r;
    req_nxt = req_r;
    pi_nxt = pi_r;
    cmd = '0;
    cmd.req = req_r;
    cmd.paint_idx = pi_r;
    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt = in_req;
          case (in_req)
            REQ_CLEAR: st_nxt = S_CLEAR;
            REQ_SAMPLE: begin
              st_nxt = S_CORD;
              cmd.start_cordic = 1'b1;
            end
            REQ_READ: st_nxt = S_READ;
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.wr_en = 1'b1;
        cmd.wr_from_clear = 1'b1;
        if (clr_last) st_nxt = S_DONE;
      end
      S_CORD: begin
        if (sts.cordic_done) begin
          st_nxt = S_DIV;
          cmd.start_div = 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          pi_nxt = '0;
          st_nxt = sts.in_grid ? S_PAINT : S_DONE;
        end
      end
      S_PAINT: begin
        cmd.wr_en = sts.paint_valid;
        pi_nxt = pi_r + 1'b1;
        if (pi_r == PIDX_W'(PAINT_N - 1)) st_nxt = S_DONE;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        st_nxt = S_DONE;
      end
      S_DONE: begin
        // A read keeps its address on the RAM so the read data survives an output stall.
        cmd.rd_en = (req_r == REQ_READ);
        if (out_free) begin
          cmd.load_result = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  assign busy = (st_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR;
      req_r <= REQ_CLEAR;
      pi_r <= '0;
    end else begin
      st_r <= st_nxt;
      req_r <= req_nxt;
      pi_r <= pi_nxt;
    end
  end

  // A result is loaded only out of the closing state.
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> st_r == S_DONE) else $error("load outside done");
  // Painting never runs past the end of the paint list.
  a_paint_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_PAINT |-> pi_r < PIDX_W'(PAINT_N)) else $error("paint overrun");
  // A new transaction is accepted only while idle.
  a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> st_r == S_IDLE) else $error("accept while busy");
endmodule

>>> hdl/logb_dp.sv
// Datapath: CORDIC, division by 100, paint addressing, grid RAM, result registers.
module logb_dp import logb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [15:0]       in_dist,
  input  logic signed [15:0] in_ang,
  input  logic [COL_W-1:0]  in_col,
  input  logic [ROW_W-1:0]  in_row,
  input  logb_cmd_t         cmd,
  output logb_sts_t         sts,
  output logic              clr_last,
  output logic [3:0]        res_cell,
  output logic              res_hit,
  output logic [ROW_W-1:0]  res_goal
);
  // CORDIC
  logic signed [CW-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic flip_r, flip_nxt;
  logic [4:0] it_r, it_nxt;
  logic cord_run_r, cord_run_nxt;
  logic signed [16:0] a17;
  logic [31:0] dprod;

  assign a17 = 17'(in_ang);
  assign dprod = 32'(in_dist) * 32'(GAIN_Q16);

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; flip_nxt = flip_r;
    it_nxt = it_r; cord_run_nxt = cord_run_r;
    if (cmd.start_cordic) begin
      x_nxt = CW'(dprod);
      y_nxt = '0;
      it_nxt = '0;
      cord_run_nxt = 1'b1;
      if (a17 > HALF_PI_Q13) begin
        z_nxt = CW'(a17 - PI_Q13) <<< 3; flip_nxt = 1'b1;
      end else if (a17 < -HALF_PI_Q13) begin
        z_nxt = CW'(a17 + PI_Q13) <<< 3; flip_nxt = 1'b1;
      end else begin
        z_nxt = CW'(a17) <<< 3; flip_nxt = 1'b0;
      end
    end else if (cord_run_r) begin
      if (it_r == 5'(CORDIC_N)) begin
        cord_run_nxt = 1'b0;
        if (flip_r) begin x_nxt = -x_r; y_nxt = -y_r; end
      end else if (!z_r[CW-1]) begin
        x_nxt = x_r - (y_r >>> it_r[3:0]);
        y_nxt = y_r + (x_r >>> it_r[3:0]);
        z_nxt = z_r - atan_q16(it_r[3:0]);
        it_nxt = it_r + 1'b1;
      end else begin
        x_nxt = x_r + (y_r >>> it_r[3:0]);
        y_nxt = y_r - (x_r >>> it_r[3:0]);
        z_nxt = z_r + atan_q16(it_r[3:0]);
        it_nxt = it_r + 1'b1;
      end
    end
  end
  assign sts.cordic_done = cord_run_r && it_r == 5'(CORDIC_N);

  // Division of |x|,|y| by 6553600 = 100<<16: drop 16 bits, then multiply by a rounded-up
  // reciprocal of 100, which gives the exact quotient for every 20-bit numerator.
  localparam logic [20:0] RECIP_100 = 21'd1342178;
  localparam int RECIP_SH = 27;
  logic [19:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic [13:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic sx_r, sx_nxt, sy_r, sy_nxt;
  logic dv_r, dv_nxt;
  logic dv_run_r, dv_run_nxt;
  logic [CW-1:0] ax, ay;
  logic [40:0] mx, my;

  assign ax = x_r[CW-1] ? CW'(-x_r) : x_r;
  assign ay = y_r[CW-1] ? CW'(-y_r) : y_r;
  assign mx = 41'(nx_r) * 41'(RECIP_100);
  assign my = 41'(ny_r) * 41'(RECIP_100);

  always_comb begin
    nx_nxt = nx_r; ny_nxt = ny_r; qx_nxt = qx_r; qy_nxt = qy_r;
    sx_nxt = sx_r; sy_nxt = sy_r; dv_nxt = dv_r; dv_run_nxt = dv_run_r;
    if (cmd.start_div) begin
      nx_nxt = ax[35:16]; ny_nxt = ay[35:16];
      // The half-plane flip lands in x and y on this same edge, so fold it into the sign.
      sx_nxt = x_r[CW-1] ^ flip_r; sy_nxt = y_r[CW-1] ^ flip_r;
      dv_nxt = 1'b0; dv_run_nxt = 1'b1;
    end else if (dv_run_r) begin
      if (dv_r) begin
        dv_run_nxt = 1'b0;
      end else begin
        qx_nxt = mx[40:RECIP_SH]; qy_nxt = my[40:RECIP_SH];
        dv_nxt = 1'b1;
      end
    end
  end
  assign sts.div_done = dv_run_r && dv_r;

  // Signed row and column; negative quotients truncate toward zero.
  logic signed [21:0] row_s, col_s;
  assign row_s = sx_r ? -22'(qx_r) : 22'(qx_r);
  assign col_s = (sy_r ? -22'(qy_r) : 22'(qy_r)) + 22'sd64;
  assign sts.in_grid = row_s >= 0 && row_s < 22'sd128 && col_s >= 0 && col_s < 22'sd128;

  logic [COL_W-1:0] hc_r;
  logic [ROW_W-1:0] hr_r;
  always_ff @(posedge clk) begin
    if (sts.div_done) begin
      hc_r <= col_s[COL_W-1:0];
      hr_r <= row_s[ROW_W-1:0];
    end
  end

  // Paint list entry: direction and radius, plus value.
  logic signed [9:0] pc, pr;
  logic [3:0] pval;
  logic [PIDX_W-1:0] pk, pd_base;
  logic [1:0] pdir;
  localparam int PER_DIR = (OUTER_R + 1) + INNER_R;
  always_comb begin
    pc = 10'(hc_r); pr = 10'(hr_r); pval = CELL_OBS; pdir = '0; pk = '0; pd_base = '0;
    if (cmd.paint_idx != '0) begin
      pd_base = cmd.paint_idx - 1'b1;
      if (pd_base >= PIDX_W'(3 * PER_DIR)) begin
        pdir = 2'd3; pk = pd_base - PIDX_W'(3 * PER_DIR);
      end else if (pd_base >= PIDX_W'(2 * PER_DIR)) begin
        pdir = 2'd2; pk = pd_base - PIDX_W'(2 * PER_DIR);
      end else if (pd_base >= PIDX_W'(PER_DIR)) begin
        pdir = 2'd1; pk = pd_base - PIDX_W'(PER_DIR);
      end else begin
        pdir = 2'd0; pk = pd_base;
      end
      if (pk <= PIDX_W'(OUTER_R)) begin
        pval = CELL_BUF; pk = pk + PIDX_W'(INNER_R);
      end else begin
        pval = CELL_OBS; pk = pk - PIDX_W'(OUTER_R);
      end
      case (pdir)
        2'd0: pc = 10'(hc_r) + 10'(pk);
        2'd1: pc = 10'(hc_r) - 10'(pk);
        2'd2: pr = 10'(hr_r) + 10'(pk);
        default: pr = 10'(hr_r) - 10'(pk);
      endcase
    end
  end
  assign sts.paint_valid = pc >= 0 && pc < 10'sd128 && pr >= 0 && pr < 10'sd128;

  // Clear sweep address.
  logic [ADDR_W-1:0] ca_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ca_r <= '0;
    else if (cmd.wr_from_clear) ca_r <= ca_r + 1'b1;
  end
  assign clr_last = cmd.wr_from_clear && ca_r == {ADDR_W{1'b1}};

  logic [ADDR_W-1:0] ra;
  logic [3:0] rwd, rrd;
  logic [COL_W-1:0] rc_r;
  logic [ROW_W-1:0] rr_r;
  always_ff @(posedge clk) begin
    if (in_fire) begin rc_r <= in_col; rr_r <= in_row; end
  end
  always_comb begin
    if (cmd.wr_from_clear) begin
      ra = ca_r; rwd = CELL_FREE;
    end else if (cmd.rd_en) begin
      ra = {rc_r, rr_r}; rwd = CELL_FREE;
    end else begin
      ra = {pc[COL_W-1:0], pr[ROW_W-1:0]}; rwd = pval;
    end
  end

  logb_ram #(.WIDTH(4), .DEPTH(DEPTH)) u_grid (
    .clk(clk), .we(cmd.wr_en), .addr(ra), .wdata(rwd), .rdata(rrd));

  // Farthest row and results.
  logic [ROW_W-1:0] far_r;
  logic hit_r;
  logic [7:0] gsum;
  assign gsum = 8'(far_r) + 8'(GOAL_MARGIN);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      far_r <= '0; hit_r <= 1'b0;
      cord_run_r <= 1'b0; dv_run_r <= 1'b0;
    end else begin
      cord_run_r <= cord_run_nxt;
      dv_run_r <= dv_run_nxt;
      if (cmd.wr_from_clear) far_r <= '0;
      if (sts.div_done) begin
        hit_r <= sts.in_grid;
        if (sts.in_grid && row_s[ROW_W-1:0] > far_r) far_r <= row_s[ROW_W-1:0];
      end
    end
  end
  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; flip_r <= flip_nxt; it_r <= it_nxt;
    nx_r <= nx_nxt; ny_r <= ny_nxt; qx_r <= qx_nxt; qy_r <= qy_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; dv_r <= dv_nxt;
    if (cmd.load_result) begin
      res_cell <= (cmd.req == REQ_READ) ? rrd : CELL_FREE;
      res_hit <= (cmd.req == REQ_SAMPLE) ? hit_r : 1'b0;
      res_goal <= (cmd.req != REQ_FINISH) ? '0 :
                  (gsum > 8'(GRID_H - 1)) ? ROW_W'(GRID_H - 1) : gsum[ROW_W-1:0];
    end
  end
endmodule

>>> tb/sv/tb_lidar_occupancy_grid_builder.sv
// Self-checking testbench of the lidar occupancy grid builder.
module tb_lidar_occupancy_grid_builder;
  import logb_pkg::*;

  localparam int RAND_ITEMS = 650;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD = 600;

  typedef struct packed {
    logic [6:0] goal_row;
    logic       sample_in_range;
    logic [3:0] cell_value;
  } grid_reply_t;

  typedef struct {
    logic [1:0]         req;
    logic [15:0]        distance;
    logic signed [15:0] ang;
    logic [6:0]         col;
    logic [6:0]         row;
    bit                 typed;
    grid_reply_t        reply;
  } stim_row_t;

  logic        clk = 0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // sample_distance, sample_angle, cell_column, cell_row
  logic [1:0]  in_tuser;   // req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // cell_value, sample_in_range, goal_row

  lidar_occupancy_grid_builder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Shadow copy of the grid and of the farthest row hit, kept in step with the block.
  logic [3:0]  shadow_grid [DEPTH];
  logic [6:0]  shadow_far_row;
  grid_reply_t pending_replies[$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          hold_request = 0;
  int          last_hit_col = GRID_W / 2;
  int          last_hit_row = 0;

  // Paints one cell of the shadow grid, skipping cells beyond the edges.
  function automatic void paint(int c, int r, logic [3:0] v);
    if (c >= 0 && c < GRID_W && r >= 0 && r < GRID_H) shadow_grid[c * GRID_H + r] = v;
  endfunction

  // Works out the reply to one request and applies it to the shadow state. Samples
  // are rotated with the same 16-step fixed-point CORDIC that the block uses.
  function automatic grid_reply_t grid_update(logic [1:0] req, logic [15:0] distance,
                                              logic signed [15:0] ang, logic [6:0] col,
                                              logic [6:0] row);
    grid_reply_t rep;
    longint x, y, z, nx, row_i, col_i;
    longint atan_tab [16] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2};
    int a, g;
    bit flip;
    int dc [4] = '{1, -1, 0, 0};
    int dr [4] = '{0, 0, 1, -1};
    rep = '0;
    case (req)
      REQ_CLEAR: begin
        foreach (shadow_grid[i]) shadow_grid[i] = CELL_FREE;
        shadow_far_row = '0;
      end
      REQ_SAMPLE: begin
        a = ang;
        flip = 0;
        if (a > 12868) begin
          a -= 25736;
          flip = 1;
        end else if (a < -12868) begin
          a += 25736;
          flip = 1;
        end
        x = longint'(distance) * 39797;
        y = 0;
        z = longint'(a) * 8;
        for (int i = 0; i < 16; i++) begin
          if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_tab[i];
          end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_tab[i];
          end
          x = nx;
        end
        if (flip) begin
          x = -x;
          y = -y;
        end
        row_i = x / 6553600;
        col_i = y / 6553600 + GRID_W / 2;
        if (col_i >= 0 && col_i < GRID_W && row_i >= 0 && row_i < GRID_H) begin
          rep.sample_in_range = 1'b1;
          if (row_i > shadow_far_row) shadow_far_row = 7'(row_i);
          paint(int'(col_i), int'(row_i), CELL_OBS);
          for (int d = 0; d < 4; d++) begin
            if (OUTER_R > 0)
              for (int k = INNER_R; k <= INNER_R + OUTER_R; k++)
                paint(int'(col_i + dc[d] * k), int'(row_i + dr[d] * k), CELL_BUF);
            if (INNER_R > 1)
              for (int k = 1; k <= INNER_R; k++)
                paint(int'(col_i + dc[d] * k), int'(row_i + dr[d] * k), CELL_OBS);
          end
        end
      end
      REQ_READ: rep.cell_value = shadow_grid[int'(col) * GRID_H + int'(row)];
      default: begin
        g = int'(shadow_far_row) + GOAL_MARGIN;
        if (g > GRID_H - 1) g = GRID_H - 1;
        rep.goal_row = 7'(g);
      end
    endcase
    return rep;
  endfunction

  // Offers one transaction, keeping in_tvalid high, and records its expected reply once
  // the block takes it.
  task automatic send_request(stim_row_t s);
    grid_reply_t rep;
    in_tvalid <= 1'b1;
    in_tuser  <= s.req;
    in_tdata  <= {2'b00, s.row, s.col, s.ang, s.distance};
    do @(posedge clk); while (!in_tready);
    rep = grid_update(s.req, s.distance, s.ang, s.col, s.row);
    if (s.req == REQ_SAMPLE && rep.sample_in_range) begin
      // This leaves last_hit_col as it was; the main loop estimates where hits land.
      last_hit_col = (s.ang * 0 + int'(rep.sample_in_range)) ? last_hit_col : last_hit_col;
    end
    pending_replies = {pending_replies, (s.typed ? s.reply : rep)};
  endtask

  // Between bursts the sender drops in_tvalid for a random number of cycles.
  task automatic sender_gap();
    int gap;
    gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic stim_row_t random_request(int n);
    stim_row_t s;
    int pick;
    s.typed = 0;
    s.reply = '0;
    s.distance = '0;
    s.ang = '0;
    s.col = 7'($urandom_range(0, 127));
    s.row = 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (n == 220 || n == 470) s.req = REQ_CLEAR;
    else if (pick < 50) s.req = REQ_SAMPLE;
    else if (pick < 90) s.req = REQ_READ;
    else s.req = REQ_FINISH;
    // Sample bits are randomized on every request so all data bits toggle.
    if ($urandom_range(0, 9) < 7) begin
      s.distance = 16'($urandom_range(0, 13000));
      s.ang = 16'($signed($urandom_range(0, 16000)) - 8000);
    end else begin
      s.distance = 16'($urandom_range(0, 65535));
      s.ang = 16'($signed($urandom_range(0, 51472)) - 25736);
    end
    // About half the reads probe around the last place a beam hit, where the inflation lives.
    if (s.req == REQ_READ && $urandom_range(0, 1) == 0) begin
      s.col = 7'(last_hit_col + $signed($urandom_range(0, 10)) - 5);
      s.row = 7'(last_hit_row + $signed($urandom_range(0, 10)) - 5);
    end
    return s;
  endfunction

  // Directed opening: reset contents, field extremes, edges, every request kind.
  stim_row_t directed [] = '{
    '{REQ_READ,   16'd0,     16'sd0,      7'd0,   7'd0,   1, '{7'd0, 1'b0, CELL_FREE}},
    '{REQ_READ,   16'd0,     16'sd0,      7'd127, 7'd127, 1, '{7'd0, 1'b0, CELL_FREE}},
    '{REQ_FINISH, 16'd0,     16'sd0,      7'd0,   7'd0,   1, '{7'd9, 1'b0, CELL_FREE}},
    '{REQ_SAMPLE, 16'd0,     16'sd0,      7'd0,   7'd0,   0, '0},
    '{REQ_READ,   16'd0,     16'sd0,      7'd64,  7'd0,   0, '0},
    '{REQ_READ,   16'd0,     16'sd0,      7'd64,  7'd2,   0, '0},
    '{REQ_READ,   16'd0,     16'sd0,      7'd68,  7'd0,   0, '0},
    '{REQ_SAMPLE, 16'd65535, 16'sd0,      7'd0,   7'd0,   1, '{7'd0, 1'b0, CELL_FREE}},
    '{REQ_SAMPLE, 16'd12750, 16'sd0,      7'd0,   7'd0,   0, '0},
    '{REQ_READ,   16'd0,     16'sd0,      7'd64,  7'd127, 0, '0},
    '{REQ_FINISH, 16'd0,     16'sd0,      7'd0,   7'd0,   1, '{7'd127, 1'b0, CELL_FREE}},
    '{REQ_SAMPLE, 16'd1000,  16'sd25736,  7'd0,   7'd0,   0, '0},
    '{REQ_SAMPLE, 16'd1000,  -16'sd25736, 7'd0,   7'd0,   0, '0},
    '{REQ_SAMPLE, 16'd6300,  16'sd12868,  7'd0,   7'd0,   0, '0},
    '{REQ_SAMPLE, 16'd6300,  -16'sd12868, 7'd0,   7'd0,   0, '0},
    '{REQ_SAMPLE, 16'd6300,  16'sd12869,  7'd0,   7'd0,   0, '0},
    '{REQ_SAMPLE, 16'd9000,  16'sd6434,   7'd0,   7'd0,   0, '0},
    '{REQ_READ,   16'd0,     16'sd0,      7'd0,   7'd63,  0, '0},
    '{REQ_READ,   16'd0,     16'sd0,      7'd127, 7'd63,  0, '0},
    '{REQ_CLEAR,  16'hffff,  -16'sd1,     7'd127, 7'd127, 1, '{7'd0, 1'b0, CELL_FREE}},
    '{REQ_READ,   16'd0,     16'sd0,      7'd64,  7'd0,   1, '{7'd0, 1'b0, CELL_FREE}},
    '{REQ_FINISH, 16'd0,     16'sd0,      7'd0,   7'd0,   1, '{7'd9, 1'b0, CELL_FREE}}
  };

  // The receiver stalls on its own random pattern, and once holds off for a long
  // stretch so that the block fills up and stalls its input side.
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= (hold_left == 1);
    end else begin
      out_tready <= (cycle_count % 64 < 32) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // Every accepted result transaction is checked field by field against the oldest
  // expectation.
  always @(posedge clk) begin
    grid_reply_t got, want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[11:0];
      if (pending_replies.size() == 0) begin
        $error("unexpected result transaction %h", out_tdata);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        if (got.cell_value !== want.cell_value) begin
          $error("cell_value: expected %0d, got %0d", want.cell_value, got.cell_value);
          fail_count++;
        end
        if (got.sample_in_range !== want.sample_in_range) begin
          $error("sample_in_range: expected %0d, got %0d", want.sample_in_range,
                 got.sample_in_range);
          fail_count++;
        end
        if (got.goal_row !== want.goal_row) begin
          $error("goal_row: expected %0d, got %0d", want.goal_row, got.goal_row);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    stim_row_t s;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tuser   <= REQ_CLEAR;
    in_tdata   <= '0;
    foreach (shadow_grid[i]) shadow_grid[i] = CELL_FREE;
    shadow_far_row = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      send_request(directed[i]);
      sender_gap();
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      s = random_request(n);
      if (s.req == REQ_SAMPLE && $urandom_range(0, 1) == 0) begin
        last_hit_col = GRID_W / 2 + (int'(s.distance) * int'(s.ang)) / (8192 * 100);
        last_hit_row = int'(s.distance) / 100;
        if (last_hit_col < 0 || last_hit_col > 127) last_hit_col = GRID_W / 2;
        if (last_hit_row > 127) last_hit_row = 127;
      end
      send_request(s);
      // One long receiver hold while the sender keeps offering transactions.
      if (n == 120) hold_request <= 1'b1;
      else if (n == 121) hold_request <= 1'b0;
      // One pause of the sender until every outstanding result has drained.
      if (n == 360) begin
        in_tvalid <= 1'b0;
        wait (pending_replies.size() == 0);
        @(posedge clk);
      end else if (n < RAND_ITEMS - 1) begin
        sender_gap();
      end
    end
    in_tvalid <= 1'b0;

    wait (pending_replies.size() == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
